// ----- hdl/rle_to_page_framebuffer_assert.svh -----
// Assertion macros shared by the framebuffer decoder modules.
`ifndef RLE_TO_PAGE_FRAMEBUFFER_ASSERT_SVH
`define RLE_TO_PAGE_FRAMEBUFFER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication under reset.
`define RTP_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rtp assertion failed: same-cycle implication");

// Next-cycle implication under reset.
`define RTP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rtp assertion failed: next-cycle implication");

`else

`define RTP_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define RTP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- hdl/rtp_pkg.sv -----
// Shared constants and types of the run-length page framebuffer.
package rtp_pkg;

	// Frame geometry
	localparam int WIDTH = 128;
	localparam int HEIGHT = 64;
	localparam int PAGES = (HEIGHT + 7) / 8;
	localparam int BUF_BYTES = WIDTH * PAGES;
	localparam int IDX_W = $clog2(BUF_BYTES);
	localparam int MEM_AW = IDX_W + 1;
	localparam int COL_W = $clog2(WIDTH);
	localparam int ROW_W = $clog2(HEIGHT);
	localparam int CNT_W = $clog2(WIDTH * HEIGHT + 1);

	// Coding
	localparam int RUN_W = 15;
	localparam logic [7:0] ESC_DARK = 8'h55;
	localparam logic [7:0] ESC_LIGHT = 8'haa;
	localparam logic [7:0] FILL_DARK = 8'h00;
	localparam logic [7:0] FILL_LIGHT = 8'hff;

	// Brightness: set pixels * 40 / 8192, saturated
	localparam int INTENSITY_SCALE = 40;
	localparam int INTENSITY_SHIFT = 13;
	localparam logic [5:0] INTENSITY_MAX = 6'd40;
	localparam logic [5:0] FRAMES_MAX = 6'd63;

	typedef logic [IDX_W-1:0] idx_t;

	// One decoded run: pattern byte repeated count times
	typedef struct packed {
		logic [7:0] pattern;
		logic [RUN_W-1:0] count;
	} run_cmd_t;

	// One pixel read-modify-write into the draw bank
	typedef struct packed {
		logic valid;
		logic bank;
		idx_t idx;
		logic [2:0] bit_sel;
		logic pixel;
	} pix_req_t;

	// One byte read from the shown bank
	typedef struct packed {
		logic valid;
		logic bank;
		idx_t idx;
	} rd_req_t;

endpackage

// ----- hdl/rtp_in_if.sv -----
// Input word channel: coded byte feed or shown-frame read request.
interface rtp_in_if;
	logic valid;
	logic ready;
	logic op;
	logic [7:0] coded_byte;
	logic [9:0] read_address;

	modport source(output valid, output op, output coded_byte, output read_address,
		input ready);
	modport sink(input valid, input op, input coded_byte, input read_address,
		output ready);
endinterface

// ----- hdl/rtp_out_if.sv -----
// Output word channel: read data, frame count and brightness.
interface rtp_out_if;
	logic valid;
	logic ready;
	logic [7:0] read_data;
	logic [5:0] frames_done;
	logic [5:0] intensity;

	modport source(output valid, output read_data, output frames_done, output intensity,
		input ready);
	modport sink(input valid, input read_data, input frames_done, input intensity,
		output ready);
endinterface

// ----- hdl/rtp_escape_dec.sv -----
// Escape decoder: turns coded bytes into pattern runs.
module rtp_escape_dec (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic [7:0] coded_byte,
	output rtp_pkg::run_cmd_t cmd
);

	typedef enum logic [1:0] {
		ESC_NONE,
		ESC_HELD_DARK,
		ESC_HELD_LIGHT
	} esc_t;

	esc_t esc_q, esc_d;
	logic [6:0] run_low_q, run_low_d;
	logic run_low_valid_q, run_low_valid_d;
	logic [7:0] fill;

	// Decode the current byte against the held escape
	always_comb begin
		esc_d = esc_q;
		run_low_d = run_low_q;
		run_low_valid_d = run_low_valid_q;
		cmd.pattern = coded_byte;
		cmd.count = '0;
		fill = (esc_q == ESC_HELD_DARK) ? rtp_pkg::FILL_DARK : rtp_pkg::FILL_LIGHT;
		unique case (esc_q) inside
			ESC_NONE: begin
				if (coded_byte == rtp_pkg::ESC_DARK) begin
					esc_d = ESC_HELD_DARK;
				end else if (coded_byte == rtp_pkg::ESC_LIGHT) begin
					esc_d = ESC_HELD_LIGHT;
				end else begin
					cmd.count = rtp_pkg::RUN_W'(1);
				end
			end
			ESC_HELD_DARK, ESC_HELD_LIGHT: begin
				if (!run_low_valid_q) begin
					if (coded_byte == 8'd0) begin
						// escaped escape: emit it as a literal
						cmd.pattern = (esc_q == ESC_HELD_DARK) ? rtp_pkg::ESC_DARK
							: rtp_pkg::ESC_LIGHT;
						cmd.count = rtp_pkg::RUN_W'(1);
						esc_d = ESC_NONE;
					end else if (!coded_byte[7]) begin
						// short run
						cmd.pattern = fill;
						cmd.count = rtp_pkg::RUN_W'(coded_byte);
						esc_d = ESC_NONE;
					end else begin
						// hold low bits of a long run
						run_low_d = coded_byte[6:0];
						run_low_valid_d = 1'b1;
					end
				end else begin
					// complete the long run
					cmd.pattern = fill;
					cmd.count = {coded_byte, run_low_q};
					esc_d = ESC_NONE;
					run_low_d = '0;
					run_low_valid_d = 1'b0;
				end
			end
			default: begin
				esc_d = ESC_NONE;
			end
		endcase
	end

	// Hold escape state between bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= ESC_NONE;
			run_low_q <= '0;
			run_low_valid_q <= 1'b0;
		end else if (take) begin
			esc_q <= esc_d;
			run_low_q <= run_low_d;
			run_low_valid_q <= run_low_valid_d;
		end
	end

endmodule

// ----- hdl/rtp_pixel_walk.sv -----
// Pixel walker: raster position, bank selection, set-pixel count, brightness.
`include "rle_to_page_framebuffer_assert.svh"

module rtp_pixel_walk (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic pixel,
	output rtp_pkg::pix_req_t pix_req,
	output logic shown_bank,
	output logic shown_valid,
	output logic frame_done,
	output logic [5:0] intensity
);

	localparam int PROD_W = rtp_pkg::CNT_W + 6;

	logic [rtp_pkg::COL_W-1:0] column_q;
	logic [rtp_pkg::ROW_W-1:0] row_q;
	logic [rtp_pkg::CNT_W-1:0] set_count_q;
	logic [rtp_pkg::CNT_W-1:0] cnt_next;
	logic [5:0] intensity_q;
	logic draw_bank_q;
	logic shown_valid_q;
	logic col_last, row_last;
	logic [PROD_W-1:0] scaled;
	logic [PROD_W-1:0] quot;
	logic [5:0] level;

	assign col_last = column_q == rtp_pkg::COL_W'(rtp_pkg::WIDTH - 1);
	assign row_last = row_q == rtp_pkg::ROW_W'(rtp_pkg::HEIGHT - 1);
	assign frame_done = step && col_last && row_last;
	assign cnt_next = set_count_q + rtp_pkg::CNT_W'(pixel);

	// Brightness of the frame that this pixel completes
	assign scaled = PROD_W'(cnt_next) * PROD_W'(rtp_pkg::INTENSITY_SCALE);
	assign quot = scaled >> rtp_pkg::INTENSITY_SHIFT;
	assign level = (quot > PROD_W'(rtp_pkg::INTENSITY_MAX)) ? rtp_pkg::INTENSITY_MAX
		: quot[5:0];

	// Address the byte of the current pixel in the draw bank
	always_comb begin
		pix_req.valid = step;
		pix_req.bank = draw_bank_q;
		pix_req.idx = rtp_pkg::IDX_W'(row_q >> 3) * rtp_pkg::IDX_W'(rtp_pkg::WIDTH)
			+ rtp_pkg::IDX_W'(column_q);
		pix_req.bit_sel = row_q[2:0];
		pix_req.pixel = pixel;
	end

	assign shown_bank = ~draw_bank_q;
	assign shown_valid = shown_valid_q;
	assign intensity = intensity_q;

	// Advance the raster; swap banks at the end of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q <= '0;
			set_count_q <= '0;
			intensity_q <= '0;
			draw_bank_q <= 1'b0;
			shown_valid_q <= 1'b0;
		end else if (step) begin
			if (col_last) begin
				column_q <= '0;
				if (row_last) begin
					row_q <= '0;
					set_count_q <= '0;
					intensity_q <= level;
					draw_bank_q <= ~draw_bank_q;
					shown_valid_q <= 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
					set_count_q <= cnt_next;
				end
			end else begin
				column_q <= column_q + 1'b1;
				set_count_q <= cnt_next;
			end
		end
	end

	`RTP_ASSERT_NEXT(a_frame_restart, clk, arst_n, frame_done, column_q == '0 && row_q == '0 && set_count_q == '0)

endmodule

// ----- hdl/rtp_page_store.sv -----
// Page store: both frame banks in one memory with pixel read-modify-write.
`include "rle_to_page_framebuffer_assert.svh"

module rtp_page_store (
	input logic clk,
	input logic arst_n,
	input rtp_pkg::pix_req_t pix_req,
	input rtp_pkg::rd_req_t rd_req,
	output logic [7:0] rd_data,
	output logic busy
);

	logic [7:0] mem [2 * rtp_pkg::BUF_BYTES];
	logic [7:0] rdata_q;
	logic [rtp_pkg::MEM_AW-1:0] pix_addr;
	logic [rtp_pkg::MEM_AW-1:0] rd_addr;
	logic wr_valid_s1;
	logic [rtp_pkg::MEM_AW-1:0] wr_addr_s1;
	logic [2:0] bit_sel_s1;
	logic pixel_s1;
	logic [7:0] keep;
	logic [7:0] merged;

	assign pix_addr = {pix_req.bank, pix_req.idx};
	assign rd_addr = pix_req.valid ? pix_addr : {rd_req.bank, rd_req.idx};

	// Keep rows above in this page, drop stale rows below, place the new pixel
	assign keep = (8'd1 << bit_sel_s1) - 8'd1;
	assign merged = (rdata_q & keep) | (8'(pixel_s1) << bit_sel_s1);

	assign rd_data = rdata_q;
	assign busy = wr_valid_s1;

	// Track a pending write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_s1 <= 1'b0;
		end else begin
			wr_valid_s1 <= pix_req.valid;
		end
	end

	// Read one byte, write back the merged byte in the following cycle
	always_ff @(posedge clk) begin
		if (pix_req.valid || rd_req.valid) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_valid_s1) begin
			mem[wr_addr_s1] <= merged;
		end
		wr_addr_s1 <= pix_addr;
		bit_sel_s1 <= pix_req.bit_sel;
		pixel_s1 <= pix_req.pixel;
	end

	`RTP_ASSERT_IMPLIES(a_one_reader, clk, arst_n, pix_req.valid, !rd_req.valid)
	`RTP_ASSERT_IMPLIES(a_no_rmw_overlap, clk, arst_n, wr_valid_s1 && pix_req.valid, wr_addr_s1 != pix_addr)
	`RTP_ASSERT_IMPLIES(a_read_after_write, clk, arst_n, rd_req.valid, !wr_valid_s1)

endmodule

// ----- hdl/rle_to_page_framebuffer.sv -----
// Top level of the run-length decoder drawing into a page-organized framebuffer.
//
// req carries one word per item: op 0 feeds a coded byte, op 1 reads a byte of
// the shown frame at read_address. rsp returns one word per item with
// read_data, frames_done and intensity.
// The block takes the next item only once the result of the last one is in the
// output register: a literal byte first draws its eight pixels, a run of N
// bytes draws 8*N pixels, an escape byte draws none and a read fetches a byte.
// Throughput is set by the single memory port: every pixel is one
// read-modify-write of its page byte, one pixel per cycle, with the write-back
// in the following cycle.
// Finished frames swap the draw and shown banks, so no copy or clear pass runs.
// After reset the position, escape state and brightness are zero and the
// shown frame reads as zero until the first frame completes; the memory itself
// is not swept.
// A stalled receiver holds the result in the output register; the block
// still takes and works on the next item, then waits before replying.
`include "rle_to_page_framebuffer_assert.svh"

module rle_to_page_framebuffer (
	input logic clk,
	input logic arst_n,
	rtp_in_if.sink req,
	rtp_out_if.source rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_READ,
		ST_REPLY
	} state_t;

	state_t state_q;
	logic [rtp_pkg::RUN_W-1:0] run_bytes_q;
	logic [7:0] pattern_q;
	logic [2:0] bit_idx_q;
	logic [5:0] frames_q;
	logic readable_q;
	logic [7:0] data_q;
	logic out_valid_q;
	logic [7:0] out_data_q;
	logic [5:0] out_frames_q;
	logic [5:0] out_intensity_q;

	logic accept;
	logic in_range;
	logic slot_free;
	logic step;
	logic pixel;
	logic store_busy;
	logic [7:0] store_rd;
	logic shown_bank;
	logic shown_valid;
	logic frame_done;
	logic [5:0] intensity;
	rtp_pkg::run_cmd_t cmd;
	rtp_pkg::pix_req_t pix_req;
	rtp_pkg::rd_req_t rd_req;

	assign req.ready = (state_q == ST_IDLE) && !store_busy;
	assign accept = req.valid && req.ready;
	assign in_range = {1'b0, req.read_address} < 11'(rtp_pkg::BUF_BYTES);
	assign slot_free = !out_valid_q || rsp.ready;
	assign step = state_q == ST_RUN;
	assign pixel = pattern_q[3'd7 - bit_idx_q];

	assign rd_req.valid = accept && req.op && in_range;
	assign rd_req.bank = shown_bank;
	assign rd_req.idx = rtp_pkg::IDX_W'(req.read_address);

	assign rsp.valid = out_valid_q;
	assign rsp.read_data = out_data_q;
	assign rsp.frames_done = out_frames_q;
	assign rsp.intensity = out_intensity_q;

	rtp_escape_dec u_dec (
		.clk(clk),
		.arst_n(arst_n),
		.take(accept && !req.op),
		.coded_byte(req.coded_byte),
		.cmd(cmd)
	);

	rtp_pixel_walk u_walk (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.pixel(pixel),
		.pix_req(pix_req),
		.shown_bank(shown_bank),
		.shown_valid(shown_valid),
		.frame_done(frame_done),
		.intensity(intensity)
	);

	rtp_page_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.pix_req(pix_req),
		.rd_req(rd_req),
		.rd_data(store_rd),
		.busy(store_busy)
	);

	// Sequence one item: decode or read, draw pixels, then reply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			run_bytes_q <= '0;
			pattern_q <= '0;
			bit_idx_q <= '0;
			frames_q <= '0;
			readable_q <= 1'b0;
			data_q <= '0;
			out_valid_q <= 1'b0;
			out_data_q <= '0;
			out_frames_q <= '0;
			out_intensity_q <= '0;
		end else begin
			// drop the sent word unless a new one replaces it
			if (rsp.valid && rsp.ready && state_q != ST_REPLY) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						frames_q <= '0;
						bit_idx_q <= '0;
						data_q <= '0;
						if (req.op) begin
							readable_q <= in_range && shown_valid;
							state_q <= ST_READ;
						end else begin
							pattern_q <= cmd.pattern;
							run_bytes_q <= cmd.count;
							state_q <= (cmd.count == '0) ? ST_REPLY : ST_RUN;
						end
					end
				end
				ST_RUN: begin
					bit_idx_q <= bit_idx_q + 1'b1;
					if (frame_done && frames_q != rtp_pkg::FRAMES_MAX) begin
						frames_q <= frames_q + 1'b1;
					end
					if (bit_idx_q == 3'd7) begin
						run_bytes_q <= run_bytes_q - 1'b1;
						if (run_bytes_q == rtp_pkg::RUN_W'(1)) begin
							state_q <= ST_REPLY;
						end
					end
				end
				ST_READ: begin
					data_q <= readable_q ? store_rd : 8'd0;
					state_q <= ST_REPLY;
				end
				ST_REPLY: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_data_q <= data_q;
						out_frames_q <= frames_q;
						out_intensity_q <= intensity;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RTP_ASSERT_IMPLIES(a_run_nonzero, clk, arst_n, state_q == ST_RUN, run_bytes_q != '0)

endmodule

// ----- tb/sv/rle_to_page_framebuffer_tb.sv -----
// Self-checking testbench for the run-length page framebuffer decoder.
module rle_to_page_framebuffer_tb;

	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;
	localparam int TOTAL_WORDS = 830;
	localparam int CALM_WORDS = 100;
	localparam int HOLD_CYCLES = 2000;
	localparam int TAIL_CYCLES = 50;
	localparam int REPORT_MAX = 10;

	typedef enum logic [1:0] {HELD_NONE, HELD_DARK, HELD_LIGHT} esc_hold_t;

	typedef struct {
		logic op;
		logic [7:0] coded;
		logic [9:0] addr;
		bit drain_first;
		bit calm;
	} feed_word_t;

	typedef struct {
		logic [7:0] read_data;
		logic [5:0] frames_done;
		logic [5:0] intensity;
	} reply_t;

	logic clk;
	logic arst_n;

	rtp_in_if req_if();
	rtp_out_if rsp_if();

	rle_to_page_framebuffer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// Stimulus and expectation stores
	feed_word_t feed_q[$];
	reply_t reply_q[$];
	int n_words;
	int taken_count;
	int hold_at;
	int errors;
	bit pending_drain;
	bit fill_calm;
	bit calm;
	bit req_took;
	int src_gap;
	int sink_gap;
	int long_hold_left;
	bit long_hold_done;

	// Decoder shadow state
	logic [7:0] draw_mem [rtp_pkg::BUF_BYTES];
	logic [7:0] shown_mem [rtp_pkg::BUF_BYTES];
	int unsigned pos_col;
	int unsigned pos_row;
	esc_hold_t held;
	logic [6:0] run_lo;
	logic run_lo_vld;
	int unsigned lit_pixels;
	logic [5:0] bright;
	int unsigned frames_now;

	always #5 clk = ~clk;

	// Publish the drawn frame, update brightness and clear the draw side
	function automatic void close_frame();
		int unsigned level;
		level = lit_pixels * rtp_pkg::INTENSITY_SCALE / (1 << rtp_pkg::INTENSITY_SHIFT);
		if (level > rtp_pkg::INTENSITY_MAX)
			level = rtp_pkg::INTENSITY_MAX;
		bright = level[5:0];
		for (int i = 0; i < rtp_pkg::BUF_BYTES; i++) begin
			shown_mem[i] = draw_mem[i];
			draw_mem[i] = '0;
		end
		lit_pixels = 0;
		if (frames_now < rtp_pkg::FRAMES_MAX)
			frames_now++;
	endfunction

	// Draw a pattern byte count times, MSB first, row by row
	function automatic void paint(input logic [7:0] pattern, input int unsigned count);
		int unsigned slot;
		for (int unsigned n = 0; n < count; n++) begin
			for (int b = 7; b >= 0; b--) begin
				if (pattern[b]) begin
					slot = (pos_row / 8) * rtp_pkg::WIDTH + pos_col;
					if (slot < rtp_pkg::BUF_BYTES && !draw_mem[slot][pos_row % 8]) begin
						draw_mem[slot][pos_row % 8] = 1'b1;
						lit_pixels++;
					end
				end
				pos_col++;
				if (pos_col >= rtp_pkg::WIDTH) begin
					pos_col = 0;
					pos_row++;
					if (pos_row >= rtp_pkg::HEIGHT) begin
						pos_row = 0;
						close_frame();
					end
				end
			end
		end
	endfunction

	// Advance the escape decoder by one coded byte
	function automatic void decode(input logic [7:0] c);
		logic [7:0] fill;
		logic [rtp_pkg::RUN_W-1:0] count;
		if (held == HELD_NONE) begin
			if (c == rtp_pkg::ESC_DARK)
				held = HELD_DARK;
			else if (c == rtp_pkg::ESC_LIGHT)
				held = HELD_LIGHT;
			else
				paint(c, 1);
			return;
		end
		fill = (held == HELD_DARK) ? rtp_pkg::FILL_DARK : rtp_pkg::FILL_LIGHT;
		if (!run_lo_vld) begin
			if (c == 8'h00) begin
				paint((held == HELD_DARK) ? rtp_pkg::ESC_DARK : rtp_pkg::ESC_LIGHT, 1);
				held = HELD_NONE;
			end else if (!c[7]) begin
				paint(fill, c);
				held = HELD_NONE;
			end else begin
				run_lo = c[6:0];
				run_lo_vld = 1'b1;
			end
		end else begin
			count = {c, run_lo};
			paint(fill, count);
			held = HELD_NONE;
			run_lo = '0;
			run_lo_vld = 1'b0;
		end
	endfunction

	// Work out the reply to one accepted word
	function automatic reply_t predict(input logic op, input logic [7:0] coded,
		input logic [9:0] addr);
		reply_t r;
		if (op == OP_READ) begin
			r.read_data = (addr < rtp_pkg::BUF_BYTES) ? shown_mem[addr] : 8'h00;
			r.frames_done = '0;
		end else begin
			frames_now = 0;
			decode(coded);
			r.read_data = '0;
			r.frames_done = frames_now[5:0];
		end
		r.intensity = bright;
		return r;
	endfunction

	function automatic void add_word(input logic op, input logic [7:0] coded,
		input logic [9:0] addr);
		feed_word_t w;
		w.op = op;
		w.coded = coded;
		w.addr = addr;
		w.drain_first = pending_drain;
		w.calm = fill_calm;
		pending_drain = 1'b0;
		feed_q.push_back(w);
		n_words++;
	endfunction

	function automatic void add_feed(input logic [7:0] coded);
		add_word(OP_FEED, coded, 10'($urandom_range(0, 1023)));
	endfunction

	function automatic void add_read(input logic [9:0] addr);
		add_word(OP_READ, 8'($urandom_range(0, 255)), addr);
	endfunction

	function automatic logic [7:0] pick_escape();
		return $urandom_range(0, 1) ? rtp_pkg::ESC_LIGHT : rtp_pkg::ESC_DARK;
	endfunction

	// Literal byte that does not open an escape
	function automatic logic [7:0] pick_literal();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == rtp_pkg::ESC_DARK || c == rtp_pkg::ESC_LIGHT);
		return c;
	endfunction

	// Upper count byte: mostly runs under half a frame, now and then up to two frames' worth
	function automatic logic [7:0] pick_count_hi();
		if ($urandom_range(0, 15) == 0)
			return 8'($urandom_range(4, 15));
		return 8'($urandom_range(0, 3));
	endfunction

	function automatic void flag_mismatch(input string why, input reply_t want,
		input reply_t got);
		errors++;
		if (errors <= REPORT_MAX)
			$display({"%0t %s: expected data=%h frames=%0d intensity=%0d,",
				" got data=%h frames=%0d intensity=%0d"},
				$realtime, why, want.read_data, want.frames_done, want.intensity,
				got.read_data, got.frames_done, got.intensity);
	endfunction

	// Drive request words at the falling edge
	always @(negedge clk) begin : drive_words
		feed_word_t nxt;
		if (arst_n && (!req_if.valid || req_took)) begin
			if (src_gap > 0) begin
				src_gap--;
				req_if.valid <= 1'b0;
			end else if (feed_q.size() == 0) begin
				req_if.valid <= 1'b0;
			end else if (feed_q[0].drain_first && reply_q.size() != 0) begin
				// hold until every reply is back
				req_if.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				src_gap = $urandom_range(1, 18) - 1;
				req_if.valid <= 1'b0;
			end else begin
				nxt = feed_q.pop_front();
				if (nxt.calm)
					calm = 1'b1;
				req_if.valid <= 1'b1;
				req_if.op <= nxt.op;
				req_if.coded_byte <= nxt.coded;
				req_if.read_address <= nxt.addr;
			end
		end
	end

	// Pace the reply side, with one long hold once the block is busy
	always @(negedge clk) begin : pace_replies
		if (arst_n) begin
			if (long_hold_left > 0) begin
				long_hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (!long_hold_done && taken_count >= hold_at) begin
				long_hold_done = 1'b1;
				long_hold_left = HOLD_CYCLES - 1;
				rsp_if.ready <= 1'b0;
			end else if (calm) begin
				rsp_if.ready <= 1'b1;
			end else if (sink_gap > 0) begin
				sink_gap--;
				rsp_if.ready <= 1'b0;
			end else if ($urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(1, 18) - 1;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Check replies, then predict for the word taken at this edge
	always @(posedge clk) begin : watch_words
		reply_t want;
		reply_t got;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got.read_data = rsp_if.read_data;
				got.frames_done = rsp_if.frames_done;
				got.intensity = rsp_if.intensity;
				if (reply_q.size() == 0) begin
					want = '{default: '0};
					flag_mismatch("reply with none pending", want, got);
				end else begin
					want = reply_q.pop_front();
					if (got.read_data !== want.read_data
						|| got.frames_done !== want.frames_done
						|| got.intensity !== want.intensity)
						flag_mismatch("reply mismatch", want, got);
				end
			end
			req_took = req_if.valid && req_if.ready;
			if (req_took) begin
				reply_q.push_back(predict(req_if.op, req_if.coded_byte,
					req_if.read_address));
				taken_count++;
			end
		end
	end

	initial begin : give_up
		#30_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : run
		int pick;
		logic [7:0] esc;
		clk = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.op = OP_FEED;
		req_if.coded_byte = '0;
		req_if.read_address = '0;
		rsp_if.ready = 1'b0;
		hold_at = 1 << 30;
		for (int i = 0; i < rtp_pkg::BUF_BYTES; i++) begin
			draw_mem[i] = '0;
			shown_mem[i] = '0;
		end
		pos_col = 0;
		pos_row = 0;
		held = HELD_NONE;
		run_lo = '0;
		run_lo_vld = 1'b0;
		lit_pixels = 0;
		bright = '0;
		frames_now = 0;

		// Directed: blank reads, literal extremes, escaped literals, runs
		add_read(10'd0);
		add_read(10'd1023);
		add_feed(8'h00);
		add_feed(8'hff);
		add_feed(rtp_pkg::ESC_DARK); add_feed(8'h00);
		add_feed(rtp_pkg::ESC_LIGHT); add_feed(8'h00);
		add_feed(rtp_pkg::ESC_DARK); add_feed(8'h01);
		add_feed(rtp_pkg::ESC_LIGHT); add_feed(8'h7f);
		// long count of zero draws nothing
		add_feed(rtp_pkg::ESC_DARK); add_feed(8'h80); add_feed(8'h00);
		// long count with only the low bits
		add_feed(rtp_pkg::ESC_LIGHT); add_feed(8'hff); add_feed(8'h00);
		// largest light run: many full frames at top brightness
		add_feed(rtp_pkg::ESC_LIGHT); add_feed(8'hff); add_feed(8'hff);
		add_read(10'd0);
		add_read(10'd1023);
		// one frame's worth of dark
		add_feed(rtp_pkg::ESC_DARK); add_feed(8'h80); add_feed(8'h08);
		add_read(10'd512);

		// Random: mostly well-formed codes, some broken sequences
		hold_at = n_words + 20;
		pending_drain = 1'b1;
		while (n_words < TOTAL_WORDS) begin
			fill_calm = (n_words >= TOTAL_WORDS - CALM_WORDS);
			pick = $urandom_range(0, 99);
			esc = pick_escape();
			if (pick < 40) begin
				add_feed(pick_literal());
			end else if (pick < 62) begin
				add_feed(esc);
				add_feed(8'($urandom_range(1, 127)));
			end else if (pick < 70) begin
				add_feed(esc);
				add_feed(8'h00);
			end else if (pick < 78) begin
				add_feed(esc);
				add_feed(8'h80 | 8'($urandom_range(0, 127)));
				add_feed(pick_count_hi());
			end else if (pick < 93) begin
				add_read(10'($urandom_range(0, 1023)));
			end else if (pick < 96) begin
				// read in the middle of an escape
				add_feed(esc);
				add_read(10'($urandom_range(0, 1023)));
				add_feed(8'($urandom_range(0, 127)));
			end else if (pick < 98) begin
				// read between the two count bytes
				add_feed(esc);
				add_feed(8'h80 | 8'($urandom_range(0, 127)));
				add_read(10'($urandom_range(0, 1023)));
				add_feed(pick_count_hi());
			end else begin
				// an escape byte taken as a run count
				add_feed(esc);
				add_feed(pick_escape());
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain: all words sent, all replies back, then a quiet tail
		while (feed_q.size() != 0 || req_if.valid || reply_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (reply_q.size() != 0)
			errors++;
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
